/* hdl/ssc_pkg.sv */
package ssc_pkg;

	localparam int unsigned SSC_MAX_SEGMENTS = 1024;
	localparam int unsigned SSC_OP_W         = 2;
	localparam int unsigned SSC_COORD_W      = 32;
	localparam int unsigned SSC_STATUS_W     = 2;
	localparam int unsigned SSC_HIT_W        = 11;

	// opcodes
	localparam logic [SSC_OP_W-1:0] OP_LOAD  = 2'd0;
	localparam logic [SSC_OP_W-1:0] OP_QUERY = 2'd1;
	localparam logic [SSC_OP_W-1:0] OP_CLEAR = 2'd2;

	// result status codes
	localparam logic [SSC_STATUS_W-1:0] ST_STORED  = 2'd0;
	localparam logic [SSC_STATUS_W-1:0] ST_FULL    = 2'd1;
	localparam logic [SSC_STATUS_W-1:0] ST_QUERY   = 2'd2;
	localparam logic [SSC_STATUS_W-1:0] ST_CLEARED = 2'd3;

	typedef struct packed {
		logic signed [SSC_COORD_W-1:0] lo;
		logic signed [SSC_COORD_W-1:0] hi;
	} seg_t;

	typedef struct packed {
		logic [SSC_STATUS_W-1:0] status;
		logic [SSC_HIT_W-1:0]    hit_count;
	} res_t;

endpackage

/* hdl/ssc_if.sv */
interface ssc_req_if import ssc_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic [SSC_OP_W-1:0]           opcode;
	logic signed [SSC_COORD_W-1:0] seg_start;
	logic signed [SSC_COORD_W-1:0] seg_end;
	logic signed [SSC_COORD_W-1:0] query_point;

	modport source (output valid, opcode, seg_start, seg_end, query_point, input ready);
	modport sink (input valid, opcode, seg_start, seg_end, query_point, output ready);
endinterface

interface ssc_rsp_if import ssc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [SSC_STATUS_W-1:0] status;
	logic [SSC_HIT_W-1:0]    hit_count;

	modport source (output valid, status, hit_count, input ready);
	modport sink (input valid, status, hit_count, output ready);
endinterface

/* hdl/ssc_seg_mem.sv */
module ssc_seg_mem import ssc_pkg::*; #(
	parameter int unsigned DEPTH = SSC_MAX_SEGMENTS,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  seg_t          wr_seg,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output seg_t          rd_seg
);

	seg_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_seg;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_seg <= mem[rd_addr];
		end
	end

endmodule

/* hdl/ssc_engine.sv */
module ssc_engine import ssc_pkg::*; #(
	parameter int unsigned MAX_SEGMENTS = SSC_MAX_SEGMENTS,
	parameter int unsigned CW = $clog2(MAX_SEGMENTS + 1),
	parameter int unsigned AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	ssc_req_if.sink       req,
	output logic          res_vld,
	output res_t          res,
	input  logic          res_free,
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output seg_t          wr_seg,
	output logic          rd_en,
	output logic [AW-1:0] rd_addr,
	input  seg_t          rd_seg
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_HOLD = 2'd2;

	logic [1:0]                    state_q;
	logic [CW-1:0]                 cnt_q;
	logic [AW-1:0]                 idx_q;
	logic                          issue_q;
	logic                          vld_s1;
	logic                          last_s1;
	logic signed [SSC_COORD_W-1:0] point_q;
	logic [SSC_HIT_W-1:0]          hits_q;
	logic [SSC_STATUS_W-1:0]       status_q;

	logic                    accept;
	logic                    is_clear;
	logic                    is_query;
	logic                    full;
	logic                    issue_last;
	logic                    hit;
	logic [SSC_STATUS_W-1:0] imm_status;

	assign req.ready  = (state_q == S_IDLE);
	assign accept     = req.valid && req.ready;
	assign is_clear   = (req.opcode == OP_CLEAR);
	assign is_query   = req.opcode[0];
	assign full       = (cnt_q == CW'(MAX_SEGMENTS));
	assign imm_status = is_clear ? ST_CLEARED : (full ? ST_FULL : ST_STORED);

	// loads/clears answer at once, or from hold if stalled; queries from hold
	assign res_vld = (state_q == S_HOLD) || (accept && !is_query);
	always_comb begin
		if (state_q == S_HOLD) begin
			res.status    = status_q;
			res.hit_count = hits_q;
		end else begin
			res.status    = imm_status;
			res.hit_count = '0;
		end
	end

	assign wr_en     = accept && !is_query && !is_clear && !full;
	assign wr_addr   = cnt_q[AW-1:0];
	assign wr_seg.lo = req.seg_start;
	assign wr_seg.hi = req.seg_end;

	assign rd_en      = issue_q;
	assign rd_addr    = idx_q;
	assign issue_last = (CW'(idx_q) == (cnt_q - CW'(1)));
	assign hit        = (rd_seg.lo <= point_q) && (point_q <= rd_seg.hi);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			issue_q  <= 1'b0;
			vld_s1   <= 1'b0;
			last_s1  <= 1'b0;
			idx_q    <= '0;
			point_q  <= '0;
			hits_q   <= '0;
			status_q <= ST_STORED;
		end else begin
			vld_s1  <= issue_q;
			last_s1 <= issue_q && issue_last;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (is_query) begin
							point_q  <= req.query_point;
							hits_q   <= '0;
							idx_q    <= '0;
							status_q <= ST_QUERY;
							if (cnt_q == '0) begin
								state_q <= S_HOLD;
							end else begin
								issue_q <= 1'b1;
								state_q <= S_SCAN;
							end
						end else begin
							if (is_clear) begin
								cnt_q <= '0;
							end else if (!full) begin
								cnt_q <= cnt_q + CW'(1);
							end
							if (!res_free) begin
								status_q <= imm_status;
								hits_q   <= '0;
								state_q  <= S_HOLD;
							end
						end
					end
				end
				S_SCAN: begin
					// issue one read a cycle, count hits in the cycle after each read is issued
					if (issue_q) begin
						idx_q <= idx_q + AW'(1);
						if (issue_last) begin
							issue_q <= 1'b0;
						end
					end
					if (vld_s1) begin
						if (hit && (hits_q != '1)) begin
							hits_q <= hits_q + SSC_HIT_W'(1);
						end
						if (last_s1) begin
							state_q <= S_HOLD;
						end
					end
				end
				S_HOLD: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* hdl/segment_stabbing_counter.sv */
// Segment stabbing counter: stores up to MAX_SEGMENTS closed signed segments
// [seg_start, seg_end] and answers point queries with the number of stored
// segments that contain the point (signed compare, both ends inclusive).
// Opcode 0 loads a segment (status 0, or status 1 when the table is full and
// the load is dropped), opcode 2 clears the table (status 3), and opcodes 1
// and 3 query query_point (status 2, hit_count holds the answer, saturating
// at 2047). Every request transfer yields exactly one response transfer, in
// order. A load or clear needs no scan. A query reads the segment
// memory one entry per cycle over its single read port, so its result reaches
// the output register after a scan over all stored segments, and the next
// request is taken in the cycle after that. A new request is taken while the
// previous response waits in the output register; a further one waits until
// that response transfers. The segment memory needs no clearing after reset:
// only entries below the stored count are ever read.
module segment_stabbing_counter import ssc_pkg::*; #(
	parameter int unsigned MAX_SEGMENTS = SSC_MAX_SEGMENTS
) (
	input  logic    clk,
	input  logic    arst_n,
	ssc_req_if.sink req,
	ssc_rsp_if.source rsp
);

	localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
	localparam int unsigned AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

	logic          res_vld;
	res_t          res;
	logic          res_free;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	seg_t          wr_seg;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	seg_t          rd_seg;

	logic rsp_vld_q;
	res_t rsp_q;

	// sequencer: decode, segment count, scan and hit counting
	ssc_engine #(
		.MAX_SEGMENTS(MAX_SEGMENTS),
		.CW(CW),
		.AW(AW)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.res_vld (res_vld),
		.res     (res),
		.res_free(res_free),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_seg  (wr_seg),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_seg  (rd_seg)
	);

	// segment table: one write port, one registered read port
	ssc_seg_mem #(
		.DEPTH(MAX_SEGMENTS),
		.AW(AW)
	) u_seg_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_seg (wr_seg),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_seg (rd_seg)
	);

	// output register: free when empty or when its content transfers now
	assign res_free = !rsp_vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (res_free) begin
			rsp_vld_q <= res_vld;
		end
	end

	// hold payload while stalled
	always_ff @(posedge clk) begin
		if (res_free && res_vld) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid     = rsp_vld_q;
	assign rsp.status    = rsp_q.status;
	assign rsp.hit_count = rsp_q.hit_count;

endmodule
